>>> sv/otbi_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// otbi_pkg: shared types for the opacity table bilinear interpolator
// Item structs, controller states, lerp and fetch selects, command and status bundles.
// ============================================================================
package otbi_pkg;

	localparam int WORD_W = 24;
	// first-stage interpolated values are held to +/-(2^36 - 1)
	localparam int K_W = 37;
	localparam logic [K_W-2:0] MID_LIMIT = '1;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic                     cmd;
		logic [5:0]               row_index;
		logic [4:0]               col_index;
		logic signed [WORD_W-1:0] table_word;
		logic signed [WORD_W-1:0] log_temp;
		logic signed [WORD_W-1:0] log_density;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] log_opacity;
		logic                     saturated;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_R_RD,
		ST_R_CMP,
		ST_C_RD,
		ST_C_CMP,
		ST_FETCH,
		ST_L_START,
		ST_MUL,
		ST_DIV,
		ST_L_END,
		ST_DONE
	} ctl_state_t;

	typedef enum logic [1:0] {
		LS_KLO,
		LS_KHI,
		LS_RES
	} lerp_sel_t;

	// the eight table words fetched per query: four axis entries and the four cells around the query point
	typedef enum logic [2:0] {
		FT_AXJ0,
		FT_AXJ1,
		FT_C00,
		FT_C01,
		FT_C10,
		FT_C11,
		FT_AXI0,
		FT_AXI1
	} fetch_t;

	typedef struct packed {
		logic      load;
		logic      srch_init;
		logic      rd_row;
		logic      row_inc;
		logic      row_fix;
		logic      rd_col;
		logic      col_inc;
		logic      col_fix;
		logic      fetch_rd;
		fetch_t    fetch_rd_idx;
		logic      fetch_cap;
		fetch_t    fetch_cap_idx;
		lerp_sel_t lsel;
		logic      md_start;
		logic      mul_step;
		logic      div_step;
		logic      md_end;
	} dp_cmd_t;

	typedef struct packed {
		logic row_more;
		logic col_more;
		logic mul_last;
		logic div_last;
	} dp_sts_t;

endpackage

>>> sv/otbi_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// otbi_ctrl: sequencer for the interpolator
// Steps the axis searches, cell fetch and the three shared lerp passes.
// ============================================================================
module otbi_ctrl import otbi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  logic    req_cmd,
	output logic    req_ready,
	input  logic    out_free,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    res_load
);

	ctl_state_t state_q, state_n;
	logic [3:0] f_q;
	lerp_sel_t  l_q;
	logic       acc;

	assign acc = req_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			f_q     <= '0;
			l_q     <= LS_KLO;
		end else begin
			state_q <= state_n;
			if (state_q == ST_PREP) begin
				f_q <= '0;
				l_q <= LS_KLO;
			end
			if (state_q == ST_FETCH)
				f_q <= f_q + 4'd1;
			if (state_q == ST_L_END) begin
				unique case (l_q)
					LS_KLO:  l_q <= LS_KHI;
					LS_KHI:  l_q <= LS_RES;
					default: l_q <= LS_RES;
				endcase
			end
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:    if (acc && req_cmd == CMD_QUERY) state_n = ST_PREP;
			ST_PREP:    state_n = ST_R_RD;
			ST_R_RD:    state_n = ST_R_CMP;
			ST_R_CMP:   state_n = sts.row_more ? ST_R_RD : ST_C_RD;
			ST_C_RD:    state_n = ST_C_CMP;
			ST_C_CMP:   state_n = sts.col_more ? ST_C_RD : ST_FETCH;
			ST_FETCH:   if (f_q == 4'd8) state_n = ST_L_START;
			ST_L_START: state_n = ST_MUL;
			ST_MUL:     if (sts.mul_last) state_n = ST_DIV;
			ST_DIV:     if (sts.div_last) state_n = ST_L_END;
			ST_L_END:   state_n = (l_q == LS_RES) ? ST_DONE : ST_L_START;
			ST_DONE:    if (out_free) state_n = ST_IDLE;
			default:    state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.lsel      = l_q;
		cmd.fetch_rd_idx  = fetch_t'(f_q[2:0]);
		cmd.fetch_cap_idx = fetch_t'(f_q[2:0] - 3'd1);
		req_ready     = 1'b0;
		res_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = acc;
			end
			ST_PREP:  cmd.srch_init = 1'b1;
			ST_R_RD:  cmd.rd_row = 1'b1;
			ST_R_CMP: begin
				cmd.row_inc = sts.row_more;
				cmd.row_fix = !sts.row_more;
			end
			ST_C_RD:  cmd.rd_col = 1'b1;
			ST_C_CMP: begin
				cmd.col_inc = sts.col_more;
				cmd.col_fix = !sts.col_more;
			end
			ST_FETCH: begin
				cmd.fetch_rd  = (f_q != 4'd8);
				cmd.fetch_cap = (f_q != 4'd0);
			end
			ST_L_START: cmd.md_start = 1'b1;
			ST_MUL:     cmd.mul_step = 1'b1;
			ST_DIV:     cmd.div_step = 1'b1;
			ST_L_END:   cmd.md_end = 1'b1;
			ST_DONE:    res_load = out_free;
			default:    ;
		endcase
	end

endmodule

>>> sv/otbi_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// otbi_dp: table memory, axis search and serial multiply/divide datapath
// Executes one controller command per cycle.
// ============================================================================
module otbi_dp import otbi_pkg::*; #(
	parameter int MAX_ROWS  = 64,
	parameter int MAX_COLS  = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  req_t                     req,
	input  logic [6:0]               rows_in_use,
	input  logic [5:0]               cols_in_use,
	input  dp_cmd_t                  cmd,
	output dp_sts_t                  sts,
	output logic signed [WORD_W-1:0] res_val,
	output logic                     res_sat
);

	localparam int RB    = $clog2(MAX_ROWS);
	localparam int CB    = $clog2(MAX_COLS);
	localparam int AB    = RB + CB;
	localparam int MEM_D = MAX_ROWS * (2 ** CB);
	localparam int LRW   = ((FRAC_BITS + 4 > WORD_W) ? FRAC_BITS + 4 : WORD_W) + 4;
	localparam int AW    = K_W + 1;
	localparam int XW    = LRW + 1;
	localparam int PW    = AW + XW;
	localparam int DW    = WORD_W + 1;
	localparam int SUMW  = PW + 2;
	localparam int CW    = $clog2(PW);

	localparam logic signed [LRW-1:0] SIX =
		{{(LRW - 3 - FRAC_BITS){1'b0}}, 3'd6, {FRAC_BITS{1'b0}}};
	localparam logic signed [SUMW-1:0] KMAX = SUMW'({1'b0, MID_LIMIT});
	localparam logic signed [SUMW-1:0] KMIN = -KMAX;
	localparam logic signed [SUMW-1:0] RMAX = SUMW'({1'b0, {(WORD_W-1){1'b1}}});
	localparam logic signed [SUMW-1:0] RMIN = -RMAX - SUMW'(1);

	logic signed [WORD_W-1:0] mem [MEM_D];
	logic signed [WORD_W-1:0] rd_q;
	logic signed [WORD_W-1:0] fc_q [8];
	logic signed [WORD_W-1:0] lt_q;
	logic signed [LRW-1:0]    lr_q;
	logic [RB-1:0]            i_q;
	logic [CB-1:0]            j_q;
	logic signed [K_W-1:0]    k_lo_q, k_hi_q, base_q;
	logic [PW-1:0]            m_q, p_q;
	logic [XW-1:0]            b_q;
	logic [DW-1:0]            d_q, rem_q;
	logic                     neg_q, dz_q;
	logic [CW-1:0]            cnt_q;
	logic signed [WORD_W-1:0] res_q;
	logic                     sat_q;

	// effective table size
	logic [8:0]    r_eff, c_eff;
	logic [RB-1:0] rows_m1;
	logic [CB-1:0] cols_m1;

	always_comb begin
		r_eff = {2'b0, rows_in_use};
		if (r_eff < 9'd3) r_eff = 9'd3;
		else if (r_eff > 9'(MAX_ROWS)) r_eff = 9'(MAX_ROWS);
		c_eff = {3'b0, cols_in_use};
		if (c_eff < 9'd3) c_eff = 9'd3;
		else if (c_eff > 9'(MAX_COLS)) c_eff = 9'(MAX_COLS);
	end
	assign rows_m1 = RB'(r_eff - 9'd1);
	assign cols_m1 = CB'(c_eff - 9'd1);

	// query log R and write decode
	logic signed [LRW-1:0] t_lr, lr_n;
	logic                  we;
	logic [AB-1:0]         wa, ra;

	assign t_lr = LRW'(req.log_temp) - SIX;
	assign lr_n = LRW'(req.log_density) - (t_lr + (t_lr <<< 1));
	assign we   = cmd.load && (req.cmd == CMD_WRITE)
	              && (9'(req.row_index) < 9'(MAX_ROWS))
	              && (9'(req.col_index) < 9'(MAX_COLS));
	assign wa   = {RB'(req.row_index), CB'(req.col_index)};

	always_comb begin
		ra = {i_q, CB'(0)};
		if (cmd.rd_col) ra = {RB'(0), j_q};
		else if (cmd.fetch_rd) begin
			unique case (cmd.fetch_rd_idx)
				FT_AXJ0: ra = {RB'(0), j_q - CB'(1)};
				FT_AXJ1: ra = {RB'(0), j_q};
				FT_C00:  ra = {i_q - RB'(1), j_q - CB'(1)};
				FT_C01:  ra = {i_q - RB'(1), j_q};
				FT_C10:  ra = {i_q, j_q - CB'(1)};
				FT_C11:  ra = {i_q, j_q};
				FT_AXI0: ra = {i_q - RB'(1), CB'(0)};
				FT_AXI1: ra = {i_q, CB'(0)};
				default: ra = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= req.table_word;
		if (cmd.rd_row || cmd.rd_col || cmd.fetch_rd) rd_q <= mem[ra];
	end

	assign sts.row_more = (i_q < rows_m1) && (rd_q < lt_q);
	assign sts.col_more = (j_q < cols_m1) && (LRW'(rd_q) < lr_q);
	assign sts.mul_last = (cnt_q == CW'(XW - 1));
	assign sts.div_last = (cnt_q == CW'(PW - 1));

	// lerp operand select
	logic signed [K_W-1:0]    y0, y1;
	logic signed [LRW-1:0]    xv;
	logic signed [WORD_W-1:0] x0, x1;
	logic signed [AW-1:0]     ydiff;
	logic signed [XW-1:0]     xdiff;
	logic signed [DW-1:0]     den;

	always_comb begin
		unique case (cmd.lsel)
			LS_KLO: begin
				y0 = K_W'(fc_q[FT_C00]); y1 = K_W'(fc_q[FT_C01]);
				x0 = fc_q[FT_AXJ0]; x1 = fc_q[FT_AXJ1]; xv = lr_q;
			end
			LS_KHI: begin
				y0 = K_W'(fc_q[FT_C10]); y1 = K_W'(fc_q[FT_C11]);
				x0 = fc_q[FT_AXJ0]; x1 = fc_q[FT_AXJ1]; xv = lr_q;
			end
			LS_RES: begin
				y0 = k_lo_q; y1 = k_hi_q;
				x0 = fc_q[FT_AXI0]; x1 = fc_q[FT_AXI1]; xv = LRW'(lt_q);
			end
			default: begin
				y0 = '0; y1 = '0; x0 = '0; x1 = '0; xv = '0;
			end
		endcase
		ydiff = AW'(y1) - AW'(y0);
		xdiff = XW'(xv) - XW'(x0);
		den   = DW'(x1) - DW'(x0);
	end

	// divider step and lerp result
	logic [DW:0]             rem_n;
	logic                    qbit;
	logic signed [PW:0]      qs;
	logic signed [SUMW-1:0]  sum;

	assign rem_n = {rem_q, p_q[PW-1]};
	assign qbit  = (rem_n >= {1'b0, d_q});
	assign qs    = dz_q ? '0 : (neg_q ? -$signed({1'b0, p_q}) : $signed({1'b0, p_q}));
	assign sum   = SUMW'(base_q) + SUMW'(qs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else begin
			if (cmd.srch_init) sat_q <= 1'b0;
			if (cmd.md_end) begin
				if (cmd.lsel == LS_RES) begin
					if (sum > RMAX || sum < RMIN) sat_q <= 1'b1;
				end else if (sum > KMAX || sum < KMIN) begin
					sat_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lt_q <= req.log_temp;
			lr_q <= lr_n;
		end
		if (cmd.srch_init) begin
			i_q <= RB'(1);
			j_q <= CB'(1);
		end
		if (cmd.row_inc) i_q <= i_q + RB'(1);
		if (cmd.row_fix && i_q == RB'(1)) i_q <= RB'(2);
		if (cmd.col_inc) j_q <= j_q + CB'(1);
		if (cmd.col_fix && j_q == CB'(1)) j_q <= CB'(2);
		if (cmd.fetch_cap) fc_q[cmd.fetch_cap_idx] <= rd_q;
		if (cmd.md_start) begin
			base_q <= y0;
			m_q    <= PW'(ydiff[AW-1] ? -ydiff : ydiff);
			b_q    <= xdiff[XW-1] ? XW'(-xdiff) : XW'(xdiff);
			d_q    <= den[DW-1] ? DW'(-den) : DW'(den);
			neg_q  <= ydiff[AW-1] ^ xdiff[XW-1] ^ den[DW-1];
			dz_q   <= (den == '0);
			p_q    <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
		end
		if (cmd.mul_step) begin
			if (b_q[0]) p_q <= p_q + m_q;
			m_q   <= m_q << 1;
			b_q   <= b_q >> 1;
			cnt_q <= sts.mul_last ? '0 : cnt_q + CW'(1);
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? DW'(rem_n - {1'b0, d_q}) : DW'(rem_n);
			p_q   <= {p_q[PW-2:0], qbit};
			cnt_q <= cnt_q + CW'(1);
		end
		if (cmd.md_end) begin
			unique case (cmd.lsel)
				LS_KLO: k_lo_q <= (sum > KMAX) ? K_W'(KMAX) : (sum < KMIN) ? K_W'(KMIN)
				                  : K_W'(sum);
				LS_KHI: k_hi_q <= (sum > KMAX) ? K_W'(KMAX) : (sum < KMIN) ? K_W'(KMIN)
				                  : K_W'(sum);
				LS_RES: res_q  <= (sum > RMAX) ? WORD_W'(RMAX) : (sum < RMIN) ? WORD_W'(RMIN)
				                  : WORD_W'(sum);
				default: ;
			endcase
		end
	end

	assign res_val = res_q;
	assign res_sat = sat_q;

endmodule

>>> sv/opacity_table_bilinear_interp_top.sv
`timescale 1ns / 1ps
// ============================================================================
// opacity_table_bilinear_interp_top: opacity table with bilinear lookup
// Loads table words and answers log opacity queries, one item at a time.
// ============================================================================
// Write item: accepted with no result; the next item may follow at once.
// Query: the input stays closed until the result enters the output register,
//   which may be held back while that register is still full. Query speed is
//   set by the one-bit-per-cycle shared multiply/divide unit and the single
//   read port walked by the axis searches.
// Reset: arst_n clears control, output valid and config (rows 58, cols 20);
//   table contents are undefined until written.
// ============================================================================
module opacity_table_bilinear_interp_top import otbi_pkg::*; #(
	parameter int MAX_ROWS  = 64,
	parameter int MAX_COLS  = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// item input
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	// result output
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	// ---------------------------------------------------------------------
	// Config registers: rows_in_use at 0x0, cols_in_use at 0x4. The user
	// must write only while idle (not enforced), so no shadowing is needed.
	// ---------------------------------------------------------------------
	logic [6:0] rows_q;
	logic [5:0] cols_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd58;
			cols_q <= 6'd20;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ROWS: rows_q <= pwdata[6:0];
				REG_COLS: cols_q <= pwdata[5:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ROWS: prdata = {25'd0, rows_q};
			REG_COLS: prdata = {26'd0, cols_q};
			default:  prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Controller and datapath
	// ---------------------------------------------------------------------
	dp_cmd_t                  cmd;
	dp_sts_t                  sts;
	logic                     res_load;
	logic                     out_free;
	logic signed [WORD_W-1:0] res_val;
	logic                     res_sat;

	otbi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_cmd  (req.cmd),
		.req_ready(req_ready),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd),
		.res_load (res_load)
	);

	otbi_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rows_in_use(rows_q),
		.cols_in_use(cols_q),
		.cmd        (cmd),
		.sts        (sts),
		.res_val    (res_val),
		.res_sat    (res_sat)
	);

	// ---------------------------------------------------------------------
	// Output register: a finished result waits here, so the input side goes
	// back to idle and can take the next item meanwhile.
	// ---------------------------------------------------------------------
	logic rsp_valid_q;
	rsp_t rsp_q;

	assign out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_q.log_opacity <= res_val;
			rsp_q.saturated   <= res_sat;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	// a query item keeps the input closed on the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req.cmd == CMD_QUERY) |=> !req_ready)
		else $error("input open right after a query item");

	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!rsp_valid_q || rsp_ready))
		else $error("result loaded over a pending item");

	// a new result only appears while a query was in progress
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared with no query in flight");
`endif

endmodule

>>> tb/sv/opacity_table_bilinear_interp_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// opacity_table_bilinear_interp_checker: result predictor and comparator
// Shadows the table and the row/column limits, predicts each query result
// and compares the returned items in order.
// ============================================================================
module opacity_table_bilinear_interp_checker import otbi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          pending,
	output int          errors
);

	localparam logic [2:0] ADDR_ROWS = 3'd0;
	localparam logic [2:0] ADDR_COLS = 3'd4;
	localparam longint K_LIM = 64'sd68719476735;
	localparam longint OUT_HI = 64'sd8388607;
	localparam longint OUT_LO = -64'sd8388608;

	logic signed [WORD_W-1:0] shadow_tab [64][32];
	logic [6:0] rows_cfg;
	logic [5:0] cols_cfg;
	rsp_t opacity_due [$];

	function automatic longint sat_clip(longint v, longint lo, longint hi, inout bit sat);
		if (v > hi) begin
			sat = 1;
			return hi;
		end
		if (v < lo) begin
			sat = 1;
			return lo;
		end
		return v;
	endfunction

	// flat when the bounding axis entries are equal
	function automatic longint lerp(longint y0, longint y1, longint x0, longint x1, longint x);
		if (x1 == x0)
			return y0;
		return y0 + ((y1 - y0) * (x - x0)) / (x1 - x0);
	endfunction

	function automatic longint at(int r, int c);
		return longint'(shadow_tab[r][c]);
	endfunction

	function automatic rsp_t predict_opacity(req_t q);
		int rows, cols, i, j;
		longint lt, lr, klo, khi, res;
		bit sat;
		rsp_t e;
		sat = 0;
		rows = (rows_cfg < 3) ? 3 : (rows_cfg > 64) ? 64 : rows_cfg;
		cols = (cols_cfg < 3) ? 3 : (cols_cfg > 32) ? 32 : cols_cfg;
		lt = longint'(q.log_temp);
		lr = longint'(q.log_density) - 3 * (lt - (64'sd6 <<< 16));
		i = 1;
		while (i < rows - 1 && at(i, 0) < lt)
			i++;
		if (i == 1)
			i = 2;
		j = 1;
		while (j < cols - 1 && at(0, j) < lr)
			j++;
		if (j == 1)
			j = 2;
		klo = lerp(at(i-1, j-1), at(i-1, j), at(0, j-1), at(0, j), lr);
		klo = sat_clip(klo, -K_LIM, K_LIM, sat);
		khi = lerp(at(i, j-1), at(i, j), at(0, j-1), at(0, j), lr);
		khi = sat_clip(khi, -K_LIM, K_LIM, sat);
		res = lerp(klo, khi, at(i-1, 0), at(i, 0), lt);
		res = sat_clip(res, OUT_LO, OUT_HI, sat);
		e.log_opacity = res[WORD_W-1:0];
		e.saturated = sat;
		return e;
	endfunction

	task automatic report(string what, rsp_t got, rsp_t want);
		$display("mismatch %s: got %h/%b want %h/%b at %0t", what,
			got.log_opacity, got.saturated, want.log_opacity, want.saturated, $realtime);
		errors++;
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg <= 7'd58;
			cols_cfg <= 6'd20;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_ROWS)
					rows_cfg <= pwdata[6:0];
				else if (paddr == ADDR_COLS)
					cols_cfg <= pwdata[5:0];
			end
			if (rsp_valid && rsp_ready) begin
				if (opacity_due.size() == 0)
					report("unexpected item", rsp, rsp);
				else begin
					rsp_t want;
					want = opacity_due.pop_front();
					if (rsp.log_opacity !== want.log_opacity)
						report("log_opacity", rsp, want);
					else if (rsp.saturated !== want.saturated)
						report("saturated", rsp, want);
				end
			end
			if (req_valid && req_ready) begin
				if (req.cmd == CMD_WRITE)
					shadow_tab[req.row_index][req.col_index] <= req.table_word;
				else
					opacity_due.push_back(predict_opacity(req));
			end
			// the queue already holds a query taken at this edge
			pending <= opacity_due.size();
		end
	end

endmodule

>>> tb/sv/opacity_table_bilinear_interp_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// opacity_table_bilinear_interp_top_tb: testbench top for the opacity table
// Loads the whole table, runs directed and random write/query items over
// several row/column settings with random gaps and stalls; a checker module
// predicts and compares every result.
// ============================================================================
module opacity_table_bilinear_interp_top_tb;
	import otbi_pkg::*;

	localparam logic [2:0] ADDR_ROWS = 3'd0;
	localparam logic [2:0] ADDR_COLS = 3'd4;
	localparam int STALL_LIMIT = 5000;
	localparam int ONE = 65536;

	logic        clk;
	logic        arst_n;
	logic        req_valid, req_ready;
	req_t        req;
	logic        rsp_valid, rsp_ready;
	rsp_t        rsp;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	int          pending, errors;

	// handshake flags from the last rising edge, read at the falling edge
	logic req_taken, rsp_taken;
	// when set, both sides run with no gaps
	bit   no_gaps;
	int   quiet = 0;

	opacity_table_bilinear_interp_top DUT (
		.clk, .arst_n, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	opacity_table_bilinear_interp_checker u_checker (
		.clk, .arst_n, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready, .pending, .errors
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		req_taken <= req_valid && req_ready;
		rsp_taken <= rsp_valid && rsp_ready;
	end

	// watchdog: cycles in which no item moves on either channel
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 18);
	endfunction

	// result side: random stall before each item
	initial begin
		int stall;
		rsp_ready = 1'b0;
		@(negedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(negedge clk); while (!rsp_taken);
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send(req_t r);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(negedge clk); while (!req_taken);
	endtask

	task automatic write_word(int r, int c, int w);
		req_t x;
		x = req_t'($urandom());
		x.log_temp = 24'($urandom());
		x.log_density = 24'($urandom());
		x.cmd = CMD_WRITE;
		x.row_index = 6'(r);
		x.col_index = 5'(c);
		x.table_word = 24'(w);
		send(x);
	endtask

	task automatic query(int lt, int ld);
		req_t x;
		x.row_index = 6'($urandom());
		x.col_index = 5'($urandom());
		x.table_word = 24'($urandom());
		x.cmd = CMD_QUERY;
		x.log_temp = 24'(lt);
		x.log_density = 24'(ld);
		send(x);
	endtask

	// query aimed inside (or just past) the table; logR = ld - 3*(lt - 6)
	task automatic aimed_query();
		int lt, lr;
		lt = $urandom_range(2 * ONE, 10 * ONE);
		lr = $urandom_range(0, 12 * ONE) - 10 * ONE;
		query(lt, lr + 3 * (lt - 6 * ONE));
	endtask

	function automatic int t_axis(int i);
		return 3 * ONE + i * 6242;
	endfunction

	function automatic int r_axis(int j);
		return -8 * ONE + j * 19026;
	endfunction

	function automatic int body_word();
		return int'($urandom_range(0, 10 * ONE)) - 5 * ONE;
	endfunction

	task automatic load_axes();
		for (int i = 1; i < 64; i++)
			write_word(i, 0, t_axis(i));
		for (int j = 1; j < 32; j++)
			write_word(0, j, r_axis(j));
	endtask

	task automatic apb_write(logic [2:0] a, logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// drain all outstanding queries, then let the datapath settle
	task automatic wait_idle();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_size(int rows, int cols);
		wait_idle();
		apb_write(ADDR_ROWS, rows);
		apb_write(ADDR_COLS, cols);
	endtask

	initial begin
		int roll, sizes_r[6], sizes_c[6];
		sizes_r = '{3, 64, 58, 17, 127, 0};
		sizes_c = '{3, 32, 20, 63, 9, 1};
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		no_gaps = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// whole table written once so no query ever reads an unwritten cell
		write_word(0, 0, body_word());
		load_axes();
		for (int i = 1; i < 64; i++)
			for (int j = 1; j < 32; j++)
				write_word(i, j, body_word());

		// directed: reset sizes, extreme fields, equal axis entries, clipping
		aimed_query();
		query(24'h7FFFFF, 24'h7FFFFF);
		query(-24'sh800000, -24'sh800000);
		query(24'h7FFFFF, -24'sh800000);
		query(-24'sh800000, 24'h7FFFFF);
		query(0, 0);
		set_size(3, 3);
		aimed_query();
		query(24'h7FFFFF, 0);
		write_word(1, 1, 24'h7FFFFF);
		write_word(1, 2, -24'sh800000);
		write_word(2, 1, -24'sh800000);
		write_word(2, 2, 24'h7FFFFF);
		query(-24'sh800000, 24'h7FFFFF);
		query(24'h7FFFFF, -24'sh800000);
		write_word(0, 2, r_axis(1)); // flat logR span
		write_word(2, 0, t_axis(1)); // flat logT span
		aimed_query();
		query(24'h7FFFFF, 24'h7FFFFF);
		write_word(0, 1, r_axis(2) - 1); // logR axis entries in falling order
		query(-24'sh800000, 24'h7FFFFF);
		write_word(63, 31, body_word());
		write_word(0, 0, 24'h7FFFFF);
		set_size(64, 32);
		aimed_query();
		query(24'h7FFFFF, -24'sh800000);
		query(-24'sh800000, 24'h7FFFFF);
		load_axes();

		// random: phases over several sizes, mostly aimed queries and body writes
		for (int n = 0; n < 1000; n++) begin
			if (n % 200 == 199) begin
				if ($urandom_range(0, 1))
					set_size(sizes_r[$urandom_range(0, 5)], sizes_c[$urandom_range(0, 5)]);
				else
					set_size($urandom_range(3, 64), $urandom_range(3, 32));
				if ($urandom_range(0, 1))
					load_axes();
			end
			if (n % 50 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 40)
				aimed_query();
			else if (roll < 50)
				query($urandom(), $urandom());
			else if (roll < 85)
				write_word($urandom_range(1, 63), $urandom_range(1, 31), body_word());
			else if (roll < 92)
				write_word($urandom_range(1, 63), 0, t_axis($urandom_range(0, 63)));
			else if (roll < 97)
				write_word(0, $urandom_range(1, 31), r_axis($urandom_range(0, 31)));
			else
				write_word($urandom(), $urandom(), $urandom());
		end

		wait_idle();
		repeat (500) @(negedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
sv/otbi_pkg.sv
sv/otbi_ctrl.sv
sv/otbi_dp.sv
sv/opacity_table_bilinear_interp_top.sv
tb/sv/opacity_table_bilinear_interp_checker.sv
tb/sv/opacity_table_bilinear_interp_top_tb.sv
